### rtl/core/lbc_pkg.sv
// Shared widths, register indexes and beat types for the segment clipper.
`default_nettype none
package lbc_pkg;

    // Coordinate and derived widths
    localparam int CW   = 24;   // coordinate, signed
    localparam int EW   = 25;   // window edge and delta, signed
    localparam int QW   = 26;   // distance term q, signed
    localparam int NUMW = 27;   // signed numerator after sign fold
    localparam int DENW = 25;   // |p|, unsigned

    localparam int DEF_PARAM_FRAC_BITS = 16;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 2'd3;

    // Input beat
    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } t_seg_in;

    // Output beat
    typedef struct packed {
        logic                 visible;
        logic signed [CW-1:0] clip_start_x;
        logic signed [CW-1:0] clip_start_y;
        logic signed [CW-1:0] clip_end_x;
        logic signed [CW-1:0] clip_end_y;
    } t_seg_out;

    // Per-segment data carried alongside the dividers
    typedef struct packed {
        logic signed [CW-1:0] x0;
        logic signed [CW-1:0] y0;
        logic signed [EW-1:0] dx;
        logic signed [EW-1:0] dy;
        logic [3:0]           pz;    // p exactly zero
        logic [3:0]           pneg;  // p negative (entry edge)
        logic [3:0]           qneg;  // q negative
    } t_side;

endpackage
`default_nettype wire

### rtl/core/line_segment_rect_clipper.sv
// Liang-Barsky segment clipper against a programmable axis-aligned window.
//
// Input channel: i_valid / o_stall with one segment beat (start and end point,
// signed Q16.8). Output channel: o_valid / i_stall with one result beat:
// visible flag and the clipped start and end points, all zero if invisible.
// Window registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write them only while no segment is in flight, as the block
// itself does not enforce it. The four per-edge dividers resolve one quotient
// bit per stage, which sets the depth.
// Throughput: one segment per cycle unless the receiver stalls a held result.
// Reset clears all valid bits and loads the default window (0, 0, 1920x1080).
// When the receiver stalls a held result, the whole pipeline freezes and
// o_stall is raised in the same cycle; nothing is dropped or repeated.
`default_nettype none
module line_segment_rect_clipper
    import lbc_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_seg_in               i_in,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_seg_out                   o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DW-1:0]     i_cfg_data
);
    localparam int F       = PARAM_FRAC_BITS;
    localparam int RSW     = F + 3;
    localparam int DIV_LAT = F + 5;
    localparam int LAT     = DIV_LAT + 5;
    localparam int C_IDX   = DIV_LAT + 2;

    logic w_en;

    // Window registers
    logic signed [CW-1:0] r_box_left;
    logic signed [CW-1:0] r_box_top;
    logic [CW-2:0]        r_box_width;
    logic [CW-2:0]        r_box_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_width  <= 23'd491520;
            r_box_height <= 23'd276480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BOX_LEFT:   r_box_left   <= $signed(i_cfg_data);
                CFG_BOX_TOP:    r_box_top    <= $signed(i_cfg_data);
                CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data[CW-2:0];
                CFG_BOX_HEIGHT: r_box_height <= i_cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // Valid bits, pipeline advances unless the held result is stalled
    logic [LAT-1:0] r_vld;

    assign o_valid = r_vld[LAT-1];
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage A: deltas and distance terms
    logic signed [EW-1:0] w_right;
    logic signed [EW-1:0] w_bottom;
    logic signed [CW-1:0] r_a_x0;
    logic signed [CW-1:0] r_a_y0;
    logic signed [EW-1:0] r_a_dx;
    logic signed [EW-1:0] r_a_dy;
    logic signed [QW-1:0] r_a_q [4];

    assign w_right  = EW'(r_box_left) + $signed(EW'(r_box_width));
    assign w_bottom = EW'(r_box_top) + $signed(EW'(r_box_height));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_x0  <= i_in.start_x;
            r_a_y0  <= i_in.start_y;
            r_a_dx  <= EW'(i_in.end_x) - EW'(i_in.start_x);
            r_a_dy  <= EW'(i_in.end_y) - EW'(i_in.start_y);
            r_a_q[0] <= QW'(i_in.start_x) - QW'(r_box_left);
            r_a_q[1] <= QW'(w_right) - QW'(i_in.start_x);
            r_a_q[2] <= QW'(i_in.start_y) - QW'(r_box_top);
            r_a_q[3] <= QW'(w_bottom) - QW'(i_in.start_y);
        end
    end

    // Stage B: fold signs into numerator and denominator
    logic signed [EW-1:0]   w_p [4];
    logic signed [NUMW-1:0] r_b_num [4];
    logic [DENW-1:0]        r_b_den [4];
    t_side                  r_b_side;
    t_side                  n_b_side;

    assign w_p[0] = -r_a_dx;
    assign w_p[1] = r_a_dx;
    assign w_p[2] = -r_a_dy;
    assign w_p[3] = r_a_dy;

    always_comb begin
        n_b_side    = '0;
        n_b_side.x0 = r_a_x0;
        n_b_side.y0 = r_a_y0;
        n_b_side.dx = r_a_dx;
        n_b_side.dy = r_a_dy;
        for (int i = 0; i < 4; i++) begin
            n_b_side.pz[i]   = (w_p[i] == '0);
            n_b_side.pneg[i] = w_p[i][EW-1];
            n_b_side.qneg[i] = r_a_q[i][QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_side <= n_b_side;
            for (int i = 0; i < 4; i++) begin
                r_b_num[i] <= w_p[i][EW-1] ? -NUMW'(r_a_q[i]) : NUMW'(r_a_q[i]);
                r_b_den[i] <= w_p[i][EW-1] ? DENW'(-w_p[i]) : DENW'(w_p[i]);
            end
        end
    end

    // Per-edge dividers
    logic signed [RSW-1:0] w_r [4];

    for (genvar e = 0; e < 4; e++) begin : g_edge
        lbc_div #(
            .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_b_num[e]),
            .i_den (r_b_den[e]),
            .o_r   (w_r[e])
        );
    end

    // Side data delay matching the dividers
    t_side r_sd [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r_b_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Stage C: entry max, exit min, visibility
    t_side                 w_cs;
    logic signed [RSW-1:0] n_c_u0;
    logic signed [RSW-1:0] n_c_u1;
    logic                  n_c_vis;
    logic signed [RSW-1:0] r_c_u0;
    logic signed [RSW-1:0] r_c_u1;
    logic                  r_c_vis;
    t_side                 r_c_side;

    assign w_cs = r_sd[DIV_LAT-1];

    always_comb begin
        n_c_u0  = '0;
        n_c_u1  = RSW'(1) <<< F;
        n_c_vis = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (w_cs.pz[i]) begin
                if (w_cs.qneg[i]) begin
                    n_c_vis = 1'b0;
                end
            end else if (w_cs.pneg[i]) begin
                if (w_r[i] > n_c_u0) begin
                    n_c_u0 = w_r[i];
                end
            end else if (w_r[i] < n_c_u1) begin
                n_c_u1 = w_r[i];
            end
        end
        if (n_c_u0 > n_c_u1) begin
            n_c_vis = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_u0   <= n_c_u0;
            r_c_u1   <= n_c_u1;
            r_c_vis  <= n_c_vis;
            r_c_side <= w_cs;
        end
    end

    // Stages D and E: endpoint multiply and round
    logic                 r_vis_d1;
    logic                 r_vis_d2;
    logic signed [CW-1:0] w_sx;
    logic signed [CW-1:0] w_sy;
    logic signed [CW-1:0] w_ex;
    logic signed [CW-1:0] w_ey;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vis_d1 <= r_c_vis;
            r_vis_d2 <= r_vis_d1;
        end
    end

    lbc_endp #(.PARAM_FRAC_BITS (PARAM_FRAC_BITS)) u_sx (
        .i_clk (i_clk), .i_en (w_en), .i_vis (r_c_vis),
        .i_u (r_c_u0), .i_d (r_c_side.dx), .i_base (r_c_side.x0),
        .o_val (w_sx)
    );

    lbc_endp #(.PARAM_FRAC_BITS (PARAM_FRAC_BITS)) u_sy (
        .i_clk (i_clk), .i_en (w_en), .i_vis (r_c_vis),
        .i_u (r_c_u0), .i_d (r_c_side.dy), .i_base (r_c_side.y0),
        .o_val (w_sy)
    );

    lbc_endp #(.PARAM_FRAC_BITS (PARAM_FRAC_BITS)) u_ex (
        .i_clk (i_clk), .i_en (w_en), .i_vis (r_c_vis),
        .i_u (r_c_u1), .i_d (r_c_side.dx), .i_base (r_c_side.x0),
        .o_val (w_ex)
    );

    lbc_endp #(.PARAM_FRAC_BITS (PARAM_FRAC_BITS)) u_ey (
        .i_clk (i_clk), .i_en (w_en), .i_vis (r_c_vis),
        .i_u (r_c_u1), .i_d (r_c_side.dy), .i_base (r_c_side.y0),
        .o_val (w_ey)
    );

    assign o_out = {r_vis_d2, w_sx, w_sy, w_ex, w_ey};

    // Checks
    a_invis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.visible |-> o_out.clip_start_x == '0 &&
        o_out.clip_start_y == '0 && o_out.clip_end_x == '0 && o_out.clip_end_y == '0)
        else $error("invisible result carries nonzero coordinates");

    a_u_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[C_IDX] && r_c_vis |-> r_c_u0 >= 0 && r_c_u0 <= r_c_u1 &&
        r_c_u1 <= (RSW'(1) <<< F))
        else $error("visible segment with parameters out of order");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

endmodule
`default_nettype wire

### rtl/core/lbc_div.sv
// Pipelined restoring divider: r = round(q*one/p), saturated to [-1, one+1].
`default_nettype none
module lbc_div
    import lbc_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [NUMW-1:0]        i_num,
    input  wire logic [DENW-1:0]               i_den,
    output logic signed [PARAM_FRAC_BITS+2:0]  o_r
);
    localparam int F   = PARAM_FRAC_BITS;
    localparam int QB  = F + 2;              // quotient bits
    localparam int NW  = NUMW + F + 2;       // signed dividend
    localparam int RW  = NW - 1;             // remainder, unsigned
    localparam int DW  = DENW + 1;           // divisor 2*den
    localparam int XW  = RW + DW + QB;       // compare width
    localparam int RSW = F + 3;

    // Stage 0: dividend 2*num*one + den, divisor 2*den
    logic signed [NW-1:0] r_n;
    logic [DW-1:0]        r_d;
    logic signed [NW-1:0] w_num_x;
    logic signed [NW-1:0] w_den_x;

    assign w_num_x = NW'(i_num);
    assign w_den_x = $signed(NW'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= (w_num_x <<< (F + 1)) + w_den_x;
            r_d <= {i_den, 1'b0};
        end
    end

    // Stage 1: sign and saturation checks, seed the bit stages
    logic [RW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_dv  [QB+1];
    logic          r_ng  [QB+1];
    logic          r_st  [QB+1];
    logic [XW-1:0] w_lim;

    assign w_lim = (XW'(r_d) << F) + (XW'(r_d) << 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= r_n[RW-1:0];
            r_q[0]   <= '0;
            r_dv[0]  <= r_d;
            r_ng[0]  <= r_n[NW-1];
            r_st[0]  <= !r_n[NW-1] && (XW'(r_n[RW-1:0]) >= w_lim);
        end
    end

    // One quotient bit per stage, msb first
    for (genvar k = 0; k < QB; k++) begin : g_bit
        logic [XW-1:0] w_sh;
        logic          w_ge;

        assign w_sh = XW'(r_dv[k]) << (QB - 1 - k);
        assign w_ge = XW'(r_rem[k]) >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? RW'(XW'(r_rem[k]) - w_sh) : r_rem[k];
                r_q[k+1]   <= r_q[k] | (QB'(w_ge) << (QB - 1 - k));
                r_dv[k+1]  <= r_dv[k];
                r_ng[k+1]  <= r_ng[k];
                r_st[k+1]  <= r_st[k];
            end
        end
    end

    // Final: apply saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ng[QB]) begin
                o_r <= -RSW'(1);
            end else if (r_st[QB]) begin
                o_r <= (RSW'(1) <<< F) + RSW'(1);
            end else begin
                o_r <= $signed({1'b0, r_q[QB]});
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/lbc_endp.sv
// One clipped coordinate: base + round(u * d / one), zero when invisible.
`default_nettype none
module lbc_endp
    import lbc_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic                          i_vis,
    input  wire logic signed [PARAM_FRAC_BITS+2:0] i_u,
    input  wire logic signed [EW-1:0]          i_d,
    input  wire logic signed [CW-1:0]          i_base,
    output logic signed [CW-1:0]               o_val
);
    localparam int F  = PARAM_FRAC_BITS;
    localparam int PW = F + 3 + EW;

    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] r_base;
    logic                 r_vis;
    logic signed [PW-1:0] w_rnd;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_u) * PW'(i_d);
            r_base <= i_base;
            r_vis  <= i_vis;
        end
    end

    // Round to nearest, ties up, then offset
    assign w_rnd = (r_prod + (PW'(1) <<< (F - 1))) >>> F;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_val <= r_vis ? r_base + CW'(w_rnd) : '0;
        end
    end

endmodule
`default_nettype wire
